@@ design/m3i_pkg.sv @@
// m3i_pkg: shared types, constants and floating-point helpers for the
// 3x3 matrix inverse unit. No dependencies.
package m3i_pkg;

    // Latency of the floating-point units, in clock cycles
    localparam int unsigned LAT_MUL   = 3;
    localparam int unsigned LAT_ADD   = 3;
    // Reciprocal divider: stages, quotient bits per stage
    localparam int unsigned RCP_STEPS = 7;
    localparam int unsigned RCP_BITS  = 4;

    localparam logic [30:0] THRESH_RESET = 31'h2B8CBCCC;   // 1e-12
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;
    localparam logic [7:0]  EXP_MAX      = 8'hFF;

    typedef struct packed {
        logic [31:0] in_r0c0;
        logic [31:0] in_r0c1;
        logic [31:0] in_r0c2;
        logic [31:0] in_r1c0;
        logic [31:0] in_r1c1;
        logic [31:0] in_r1c2;
        logic [31:0] in_r2c0;
        logic [31:0] in_r2c1;
        logic [31:0] in_r2c2;
    } in_t;

    typedef struct packed {
        logic        invertible;
        logic [31:0] out_r0c0;
        logic [31:0] out_r0c1;
        logic [31:0] out_r0c2;
        logic [31:0] out_r1c0;
        logic [31:0] out_r1c1;
        logic [31:0] out_r1c2;
        logic [31:0] out_r2c0;
        logic [31:0] out_r2c1;
        logic [31:0] out_r2c2;
    } out_t;

    // Leading zero count; narrower words are padded with ones below
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else      n = n + 6'd1;
            end
        end
        return n;
    endfunction

    // Round to nearest even and pack.
    // sig[25] is the leading one, sig[25:2] the significand, sig[1] guard,
    // sig[0] sticky. e is the biased exponent of the leading one; values
    // below the normal range are shifted down into a subnormal.
    function automatic logic [31:0] round_pack(input logic              sign,
                                               input logic signed [9:0] e,
                                               input logic [25:0]       sig);
        logic signed [9:0] eu;
        logic [9:0]        sh_full;
        logic [4:0]        sh;
        logic [51:0]       ext;
        logic [25:0]       s2;
        logic              inc;
        logic [24:0]       m;
        logic [32:0]       pk;
        logic [31:0]       res;
        eu      = (e < 10'sd1) ? 10'sd1 : e;
        sh_full = 10'(eu - e);
        sh      = (sh_full > 10'd26) ? 5'd26 : sh_full[4:0];
        ext     = {sig, 26'b0} >> sh;
        s2      = {ext[51:27], ext[26] | (|ext[25:0])};
        inc     = s2[1] & (s2[0] | s2[2]);
        m       = {1'b0, s2[25:2]} + {24'b0, inc};
        // hidden bit carries into the exponent field
        pk      = {1'b0, 9'(eu - 10'sd1), 23'b0} + {8'b0, m};
        if (pk[32:23] >= 10'd255)
            res = {sign, EXP_MAX, 23'b0};
        else
            res = {sign, pk[30:0]};
        return res;
    endfunction

endpackage

@@ design/m3i_fmul.sv @@
// m3i_fmul: three-stage binary32 multiplier, round to nearest even,
// subnormals kept, NaN results canonical. Depends on m3i_pkg.
module m3i_fmul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic              a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [7:0]        ea, eb;
    logic [23:0]       ma, mb;
    logic signed [9:0] epre;

    logic [47:0]       p_reg;
    logic signed [9:0] e1_reg;
    logic              sign1_reg, nan1_reg, inf1_reg, zero1_reg;

    logic [5:0]        lz;
    logic [47:0]       pn;
    logic signed [9:0] e2_next;
    logic [25:0]       sig_next;

    logic [25:0]       sig_reg;
    logic signed [9:0] e2_reg;
    logic              sign2_reg, nan2_reg, inf2_reg, zero2_reg;

    logic [31:0]       y_reg;
    logic [31:0]       y_next;

    // Stage 1: unpack and multiply significands
    always_comb
    begin
        a_zero = (a[30:0] == 31'b0);
        b_zero = (b[30:0] == 31'b0);
        a_inf  = (a[30:23] == m3i_pkg::EXP_MAX) && (a[22:0] == 23'b0);
        b_inf  = (b[30:23] == m3i_pkg::EXP_MAX) && (b[22:0] == 23'b0);
        a_nan  = (a[30:23] == m3i_pkg::EXP_MAX) && (a[22:0] != 23'b0);
        b_nan  = (b[30:23] == m3i_pkg::EXP_MAX) && (b[22:0] != 23'b0);
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        epre   = $signed({2'b0, ea}) + $signed({2'b0, eb}) - 10'sd126;
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= ma * mb;
        e1_reg    <= epre;
        sign1_reg <= a[31] ^ b[31];
        nan1_reg  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
        inf1_reg  <= a_inf | b_inf;
        zero1_reg <= a_zero | b_zero;
    end

    // Stage 2: normalize the product
    always_comb
    begin
        lz       = m3i_pkg::lzc48(p_reg);
        pn       = p_reg << lz;
        e2_next  = e1_reg - $signed({4'b0, lz});
        sig_next = {pn[47:24], pn[23], |pn[22:0]};
    end

    always_ff @(posedge clk)
    begin
        sig_reg   <= sig_next;
        e2_reg    <= e2_next;
        sign2_reg <= sign1_reg;
        nan2_reg  <= nan1_reg;
        inf2_reg  <= inf1_reg;
        zero2_reg <= zero1_reg;
    end

    // Stage 3: round and handle special operands
    always_comb
    begin
        if (nan2_reg)
            y_next = m3i_pkg::CANON_NAN;
        else if (inf2_reg)
            y_next = {sign2_reg, m3i_pkg::EXP_MAX, 23'b0};
        else if (zero2_reg)
            y_next = {sign2_reg, 31'b0};
        else
            y_next = m3i_pkg::round_pack(sign2_reg, e2_reg, sig_reg);
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

@@ design/m3i_fadd.sv @@
// m3i_fadd: three-stage binary32 adder, round to nearest even,
// subnormals kept, NaN results canonical. Depends on m3i_pkg.
module m3i_fadd (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic              a_inf, b_inf, a_nan, b_nan, swap;
    logic [31:0]       big, sml;
    logic [7:0]        eb, es, d;
    logic [4:0]        dc;
    logic [23:0]       mbig, msml;
    logic [53:0]       ext;
    logic [26:0]       al;
    logic [27:0]       sum_next;

    logic [27:0]       sum_reg;
    logic [7:0]        eb_reg;
    logic              sign1_reg, zs1_reg, nan1_reg, inf1_reg, isgn1_reg;

    logic [5:0]        lz;
    logic [27:0]       n;
    logic signed [9:0] e2_next;

    logic [25:0]       sig_reg;
    logic signed [9:0] e2_reg;
    logic              sign2_reg, zs2_reg, nan2_reg, inf2_reg, isgn2_reg, zero2_reg;

    logic [31:0]       y_reg;
    logic [31:0]       y_next;

    // Stage 1: order by magnitude, align, add or subtract
    always_comb
    begin
        a_inf    = (a[30:23] == m3i_pkg::EXP_MAX) && (a[22:0] == 23'b0);
        b_inf    = (b[30:23] == m3i_pkg::EXP_MAX) && (b[22:0] == 23'b0);
        a_nan    = (a[30:23] == m3i_pkg::EXP_MAX) && (a[22:0] != 23'b0);
        b_nan    = (b[30:23] == m3i_pkg::EXP_MAX) && (b[22:0] != 23'b0);
        swap     = (b[30:0] > a[30:0]);
        big      = swap ? b : a;
        sml      = swap ? a : b;
        eb       = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es       = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig     = {|big[30:23], big[22:0]};
        msml     = {|sml[30:23], sml[22:0]};
        d        = eb - es;
        dc       = (d > 8'd27) ? 5'd27 : d[4:0];
        ext      = {msml, 3'b0, 27'b0} >> dc;
        al       = {ext[53:28], ext[27] | (|ext[26:0])};
        if (big[31] ^ sml[31])
            sum_next = {1'b0, mbig, 3'b0} - {1'b0, al};
        else
            sum_next = {1'b0, mbig, 3'b0} + {1'b0, al};
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        eb_reg    <= eb;
        sign1_reg <= big[31];
        zs1_reg   <= a[31] & b[31];
        nan1_reg  <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
        inf1_reg  <= a_inf | b_inf;
        isgn1_reg <= a_inf ? a[31] : b[31];
    end

    // Stage 2: normalize
    always_comb
    begin
        lz      = m3i_pkg::lzc48({sum_reg, 20'hFFFFF});
        n       = sum_reg << lz;
        e2_next = $signed({2'b0, eb_reg}) + 10'sd1 - $signed({4'b0, lz});
    end

    always_ff @(posedge clk)
    begin
        sig_reg   <= {n[27:4], n[3], |n[2:0]};
        e2_reg    <= e2_next;
        sign2_reg <= sign1_reg;
        zs2_reg   <= zs1_reg;
        nan2_reg  <= nan1_reg;
        inf2_reg  <= inf1_reg;
        isgn2_reg <= isgn1_reg;
        zero2_reg <= (sum_reg == 28'b0);
    end

    // Stage 3: round; exact cancellation gives +0 unless both are -0
    always_comb
    begin
        if (nan2_reg)
            y_next = m3i_pkg::CANON_NAN;
        else if (inf2_reg)
            y_next = {isgn2_reg, m3i_pkg::EXP_MAX, 23'b0};
        else if (zero2_reg)
            y_next = {zs2_reg, 31'b0};
        else
            y_next = m3i_pkg::round_pack(sign2_reg, e2_reg, sig_reg);
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

@@ design/matrix3_inverse_unit.sv @@
// matrix3_inverse_unit: single-precision 3x3 matrix inverse by adjugate.
// Depends on m3i_pkg, m3i_fmul and m3i_fadd.
//
// A matrix is taken at every clock edge with start high; busy stays low,
// so a new item may enter every cycle. Each result leaves in the order
// its item was taken, shown for one cycle with done high; the receiver cannot
// hold it off. Each item passes through a chain of floating-point steps:
// products, cofactor differences, determinant (three more units), the
// reciprocal divider at four quotient bits per stage over seven stages,
// its rounding, the final scaling and the output register. The singular
// threshold may be written through cfg_valid/cfg_data, which is always
// ready; write it only while no item is in flight.
module matrix3_inverse_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  m3i_pkg::in_t        matrix,
    output logic                done,
    output m3i_pkg::out_t       result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data
);

    localparam int unsigned PIPE_LEN = 28;
    localparam int unsigned ROW_DLY  = m3i_pkg::LAT_MUL + m3i_pkg::LAT_ADD;
    localparam int unsigned ADJ_DLY  = 18;
    localparam int unsigned SING_DLY = 11;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] e;
        logic [23:0]       md;
        logic [24:0]       r;
        logic [27:0]       q;
    } rcp_t;

    logic [30:0]           thr_reg;
    logic [PIPE_LEN-1:0]   vld_reg;

    logic [31:0]           pa [18];
    logic [31:0]           pb [18];
    logic [31:0]           prod [18];
    logic [31:0]           sa [10];
    logic [31:0]           sb [10];
    logic [31:0]           cr [10];

    logic [2:0][31:0]      row0_dly_reg [ROW_DLY];
    logic [31:0]           dm [3];
    logic [31:0]           dt [3];
    logic [31:0]           t2_dly_reg [m3i_pkg::LAT_ADD];
    logic [31:0]           d1, det;

    logic                  mag_nan, thr_nan, sing_next;
    logic [7:0]            dexp;
    logic [23:0]           md0;
    logic [5:0]            dlz;
    logic signed [9:0]     ed;
    rcp_t                  rcp_first;
    logic                  sing_c_reg;
    logic                  sing_dly_reg [SING_DLY];

    rcp_t                  rcp_reg [m3i_pkg::RCP_STEPS + 1];
    rcp_t                  rcp_next [m3i_pkg::RCP_STEPS];

    logic                  rst_sticky;
    logic [25:0]           rsig;
    logic signed [9:0]     re;
    logic [31:0]           inv_next, inv_reg;

    logic [8:0][31:0]      adj_dly_reg [ADJ_DLY];
    logic [31:0]           scl [9];
    m3i_pkg::out_t         res_next, res_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= m3i_pkg::THRESH_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Valid bits travel beside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_LEN-2:0], start & ~busy};
    end

    // Products for the adjugate and the determinant cofactors
    always_comb
    begin
        pa[0]  = matrix.in_r1c1; pb[0]  = matrix.in_r2c2;
        pa[1]  = matrix.in_r1c2; pb[1]  = matrix.in_r2c1;
        pa[2]  = matrix.in_r0c2; pb[2]  = matrix.in_r2c1;
        pa[3]  = matrix.in_r0c1; pb[3]  = matrix.in_r2c2;
        pa[4]  = matrix.in_r0c1; pb[4]  = matrix.in_r1c2;
        pa[5]  = matrix.in_r0c2; pb[5]  = matrix.in_r1c1;
        pa[6]  = matrix.in_r1c2; pb[6]  = matrix.in_r2c0;
        pa[7]  = matrix.in_r1c0; pb[7]  = matrix.in_r2c2;
        pa[8]  = matrix.in_r0c0; pb[8]  = matrix.in_r2c2;
        pa[9]  = matrix.in_r0c2; pb[9]  = matrix.in_r2c0;
        pa[10] = matrix.in_r0c2; pb[10] = matrix.in_r1c0;
        pa[11] = matrix.in_r0c0; pb[11] = matrix.in_r1c2;
        pa[12] = matrix.in_r1c0; pb[12] = matrix.in_r2c1;
        pa[13] = matrix.in_r1c1; pb[13] = matrix.in_r2c0;
        pa[14] = matrix.in_r0c1; pb[14] = matrix.in_r2c0;
        pa[15] = matrix.in_r0c0; pb[15] = matrix.in_r2c1;
        pa[16] = matrix.in_r0c0; pb[16] = matrix.in_r1c1;
        pa[17] = matrix.in_r0c1; pb[17] = matrix.in_r1c0;
    end

    for (genvar i = 0; i < 18; i++)
    begin : g_prod
        m3i_fmul u_mul (.clk(clk), .a(pa[i]), .b(pb[i]), .y(prod[i]));
    end

    // Cross differences: nine adjugate entries, then the middle cofactor
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            sa[k] = prod[2*k];
            sb[k] = {~prod[2*k+1][31], prod[2*k+1][30:0]};
        end
        sa[9] = prod[7];
        sb[9] = {~prod[6][31], prod[6][30:0]};
    end

    for (genvar k = 0; k < 10; k++)
    begin : g_cross
        m3i_fadd u_sub (.clk(clk), .a(sa[k]), .b(sb[k]), .y(cr[k]));
    end

    // First row waits for the cofactors
    always_ff @(posedge clk)
    begin
        row0_dly_reg[0] <= {matrix.in_r0c2, matrix.in_r0c1, matrix.in_r0c0};
        for (int i = 1; i < ROW_DLY; i++)
            row0_dly_reg[i] <= row0_dly_reg[i-1];
    end

    assign dm[0] = row0_dly_reg[ROW_DLY-1][0];
    assign dm[1] = row0_dly_reg[ROW_DLY-1][1];
    assign dm[2] = row0_dly_reg[ROW_DLY-1][2];

    // Determinant terms
    m3i_fmul u_dt0 (.clk(clk), .a(dm[0]), .b(cr[0]), .y(dt[0]));
    m3i_fmul u_dt1 (.clk(clk), .a(dm[1]), .b(cr[9]), .y(dt[1]));
    m3i_fmul u_dt2 (.clk(clk), .a(dm[2]), .b(cr[6]), .y(dt[2]));

    // Left-to-right sum of the three terms
    m3i_fadd u_d1 (.clk(clk), .a(dt[0]), .b({~dt[1][31], dt[1][30:0]}), .y(d1));

    always_ff @(posedge clk)
    begin
        t2_dly_reg[0] <= dt[2];
        for (int i = 1; i < m3i_pkg::LAT_ADD; i++)
            t2_dly_reg[i] <= t2_dly_reg[i-1];
    end

    m3i_fadd u_det (.clk(clk), .a(d1), .b(t2_dly_reg[m3i_pkg::LAT_ADD-1]), .y(det));

    // Singular test and divisor normalization
    always_comb
    begin
        mag_nan   = (det[30:23] == m3i_pkg::EXP_MAX) && (det[22:0] != 23'b0);
        thr_nan   = (thr_reg[30:23] == m3i_pkg::EXP_MAX) && (thr_reg[22:0] != 23'b0);
        sing_next = !mag_nan && !thr_nan && (det[30:0] <= thr_reg);
        dexp      = det[30:23];
        md0       = {|dexp, det[22:0]};
        dlz       = (dexp == 8'd0) ? m3i_pkg::lzc48({md0, 24'hFFFFFF}) : 6'd0;
        ed        = (dexp == 8'd0) ? (10'sd1 - $signed({4'b0, dlz}))
                                   : $signed({2'b0, dexp});
        rcp_first.sign = det[31];
        rcp_first.nan  = mag_nan;
        rcp_first.inf  = (det[30:0] == 31'b0);
        rcp_first.zero = (dexp == m3i_pkg::EXP_MAX) && (det[22:0] == 23'b0);
        rcp_first.e    = 10'sd253 - ed;
        rcp_first.md   = md0 << dlz;
        rcp_first.r    = 25'h0800000;
        rcp_first.q    = '0;
    end

    always_ff @(posedge clk)
    begin
        rcp_reg[0] <= rcp_first;
        sing_c_reg <= sing_next;
    end

    // Restoring divider for 2^50 / md, four quotient bits per stage
    for (genvar k = 0; k < m3i_pkg::RCP_STEPS; k++)
    begin : g_div
        always_comb
        begin
            rcp_t t;
            t = rcp_reg[k];
            for (int i = 0; i < m3i_pkg::RCP_BITS; i++)
            begin
                if (t.r >= {1'b0, t.md})
                begin
                    t.r = t.r - {1'b0, t.md};
                    t.q[27 - (k * m3i_pkg::RCP_BITS + i)] = 1'b1;
                end
                t.r = t.r << 1;
            end
            rcp_next[k] = t;
        end

        always_ff @(posedge clk)
        begin
            rcp_reg[k+1] <= rcp_next[k];
        end
    end

    // Round the reciprocal
    always_comb
    begin
        rst_sticky = |rcp_reg[m3i_pkg::RCP_STEPS].r;
        if (rcp_reg[m3i_pkg::RCP_STEPS].q[27])
        begin
            rsig = {rcp_reg[m3i_pkg::RCP_STEPS].q[27:3],
                    |rcp_reg[m3i_pkg::RCP_STEPS].q[2:0] | rst_sticky};
            re   = rcp_reg[m3i_pkg::RCP_STEPS].e + 10'sd1;
        end
        else
        begin
            rsig = {rcp_reg[m3i_pkg::RCP_STEPS].q[26:2],
                    |rcp_reg[m3i_pkg::RCP_STEPS].q[1:0] | rst_sticky};
            re   = rcp_reg[m3i_pkg::RCP_STEPS].e;
        end
        if (rcp_reg[m3i_pkg::RCP_STEPS].nan)
            inv_next = m3i_pkg::CANON_NAN;
        else if (rcp_reg[m3i_pkg::RCP_STEPS].inf)
            inv_next = {rcp_reg[m3i_pkg::RCP_STEPS].sign, m3i_pkg::EXP_MAX, 23'b0};
        else if (rcp_reg[m3i_pkg::RCP_STEPS].zero)
            inv_next = {rcp_reg[m3i_pkg::RCP_STEPS].sign, 31'b0};
        else
            inv_next = m3i_pkg::round_pack(rcp_reg[m3i_pkg::RCP_STEPS].sign, re, rsig);
    end

    always_ff @(posedge clk)
    begin
        inv_reg <= inv_next;
    end

    // Adjugate and singular flag wait for the reciprocal
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 9; j++)
            adj_dly_reg[0][j] <= cr[j];
        for (int i = 1; i < ADJ_DLY; i++)
            adj_dly_reg[i] <= adj_dly_reg[i-1];
        sing_dly_reg[0] <= sing_c_reg;
        for (int i = 1; i < SING_DLY; i++)
            sing_dly_reg[i] <= sing_dly_reg[i-1];
    end

    for (genvar j = 0; j < 9; j++)
    begin : g_scale
        m3i_fmul u_scl (.clk(clk), .a(adj_dly_reg[ADJ_DLY-1][j]), .b(inv_reg), .y(scl[j]));
    end

    // Output register; a singular matrix gives all zeros
    always_comb
    begin
        if (sing_dly_reg[SING_DLY-1])
            res_next = '0;
        else
        begin
            res_next.invertible = 1'b1;
            res_next.out_r0c0   = scl[0];
            res_next.out_r0c1   = scl[1];
            res_next.out_r0c2   = scl[2];
            res_next.out_r1c0   = scl[3];
            res_next.out_r1c1   = scl[4];
            res_next.out_r1c2   = scl[5];
            res_next.out_r2c0   = scl[6];
            res_next.out_r2c1   = scl[7];
            res_next.out_r2c2   = scl[8];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign done   = vld_reg[PIPE_LEN-1];

endmodule
